/* rtl/v1d_pkg.sv */
// Shared types, constants and helpers for the Video 1 16-bit block decoder.
`default_nettype none
package v1d_pkg;

  localparam int MAX_SIDE_BLOCKS = 256;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [8:0] W_RST = 9'd40;
  localparam logic [8:0] H_RST = 9'd30;
  localparam logic signed [10:0] TOP_RST = 11'(4 * int'(H_RST) - 1);
  localparam logic [16:0] BL_RST = 17'(int'(W_RST) * int'(H_RST) + 1);

  // code byte values
  localparam logic [7:0] CODE_SKIP_LO = 8'h84;
  localparam logic [7:0] CODE_SKIP_HI = 8'h87;
  localparam logic [7:0] CODE_FILL    = 8'h80;

  // byte phases
  localparam logic [4:0] PH_CODE_LO  = 5'd0;
  localparam logic [4:0] PH_CODE_HI  = 5'd1;
  localparam logic [4:0] PH_COLORS   = 5'd2;
  localparam logic [4:0] PH_TWO_END  = 5'd6;
  localparam logic [4:0] PH_EIGHT_END = 5'd18;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SKIP,
    ST_END
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_pix;
    logic load_end;
    logic skip_step;
  } cmd_t;

  typedef struct packed {
    logic dec_emit;
    logic dec_skip;
    logic dec_end;
    logic pix_last;
    logic skip_last;
    logic out_free;
  } status_t;

  function automatic logic [8:0] clamp_side(input logic [8:0] v);
    logic [8:0] r;
    if (v == 9'd0) begin
      r = 9'd1;
    end else if (v > 9'(MAX_SIDE_BLOCKS)) begin
      r = 9'(MAX_SIDE_BLOCKS);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/v1d_ctrl.sv */
// Controller state machine: byte intake, pixel emission, skip walk, end result.
`default_nettype none
module v1d_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire v1d_pkg::status_t  sts,
  output v1d_pkg::cmd_t          cmd
);

  v1d_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= v1d_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      v1d_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.dec_end) begin
            state_nxt = v1d_pkg::ST_END;
          end else if (sts.dec_emit) begin
            state_nxt = v1d_pkg::ST_EMIT;
          end else if (sts.dec_skip) begin
            state_nxt = v1d_pkg::ST_SKIP;
          end
        end
      end
      v1d_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_pix = 1'b1;
          if (sts.pix_last) begin
            state_nxt = v1d_pkg::ST_IDLE;
          end
        end
      end
      v1d_pkg::ST_SKIP: begin
        cmd.skip_step = 1'b1;
        if (sts.skip_last) begin
          state_nxt = v1d_pkg::ST_IDLE;
        end
      end
      v1d_pkg::ST_END: begin
        if (sts.out_free) begin
          cmd.load_end = 1'b1;
          state_nxt    = v1d_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = v1d_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/v1d_datapath.sv */
// Datapath: config, code and color registers, block position, output register.
`default_nettype none
module v1d_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [v1d_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [v1d_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [7:0]                        in_byte,
  input  wire logic                              in_frame_start,
  input  wire logic                              out_ready,
  input  wire v1d_pkg::cmd_t                     cmd,
  output v1d_pkg::status_t                       sts,
  output logic                                   out_valid,
  output logic [9:0]                             out_pix_x,
  output logic [9:0]                             out_pix_y,
  output logic [14:0]                            out_color,
  output logic                                   out_block_last,
  output logic                                   out_frame_end
);

  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_TWO,
    MODE_EIGHT
  } mode_t;

  // control state
  logic [8:0]         width_r, height_r, width_nxt, height_nxt;
  logic [4:0]         phase_r, phase_nxt;
  logic [7:0]         code_lo_r, code_lo_nxt, code_hi_r, code_hi_nxt;
  logic [8:0]         col_r, col_nxt;
  logic signed [10:0] top_row_r, top_row_nxt;
  logic [16:0]        bl_r, bl_nxt;
  logic               fin_r, fin_nxt;
  logic [3:0]         k_r, k_nxt;
  logic [9:0]         rem_r, rem_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload
  logic [15:0] cw_r [8];
  logic [15:0] cw_nxt [8];
  mode_t       mode_r, mode_nxt;
  logic [9:0]  px_r, px_nxt, py_r, py_nxt;
  logic [14:0] color_r, color_nxt;
  logic        last_r, last_nxt, end_r, end_nxt;

  // derived values
  logic [8:0]         w, h;
  logic [17:0]        wh;
  logic signed [10:0] top_start;
  logic [16:0]        bl_start;
  logic               run;
  logic [16:0]        bl_dec, bl_skip;
  logic               hi_end, hi_skip, hi_fill;
  logic [9:0]         skip_cnt;
  logic [4:0]         phase_inc, cw_pos;
  logic [2:0]         cw_sel;
  logic               emit_two, emit_eight;
  logic [8:0]         col_inc;
  logic signed [10:0] tr_wrap;
  logic               adv_wrap;
  logic [8:0]         steps;
  logic               mask_bit;
  logic [2:0]         rd_sel;
  logic [15:0]        mask;
  logic [14:0]        pix_color;

  assign w         = v1d_pkg::clamp_side(width_r);
  assign h         = v1d_pkg::clamp_side(height_r);
  assign wh        = w * h;
  assign top_start = signed'({h, 2'b00} - 11'd1);
  assign bl_start  = wh[16:0] + 17'd1;

  assign run       = !in_frame_start && !fin_r;
  assign bl_dec    = bl_r - 17'd1;
  assign skip_cnt  = {in_byte[1:0], code_lo_r};
  assign bl_skip   = bl_r - {7'd0, skip_cnt};
  assign hi_end    = ((code_lo_r == 8'd0) && (in_byte == 8'd0) && (bl_dec == 17'd0))
                     || (top_row_r < 11'sd0);
  assign hi_skip   = in_byte inside {[v1d_pkg::CODE_SKIP_LO : v1d_pkg::CODE_SKIP_HI]};
  assign hi_fill   = in_byte >= v1d_pkg::CODE_FILL;

  assign phase_inc  = phase_r + 5'd1;
  assign cw_pos     = phase_r - v1d_pkg::PH_COLORS;
  assign cw_sel     = cw_pos[3:1];
  assign emit_two   = (phase_inc == v1d_pkg::PH_TWO_END) && !cw_r[0][15];
  assign emit_eight = (phase_inc == v1d_pkg::PH_EIGHT_END);

  // block advance and row wrap (row saturates at -1)
  assign col_inc  = col_r + 9'd1;
  assign adv_wrap = col_inc >= w;
  assign tr_wrap  = (top_row_r < 11'sd4) ? -11'sd1 : top_row_r - 11'sd4;

  // blocks until the next row wrap
  assign steps = (col_r >= w) ? 9'd1 : w - col_r;

  // pixel color select
  assign mask     = {code_hi_r, code_lo_r};
  assign mask_bit = mask[k_r];
  always_comb begin
    case (mode_r)
      MODE_EIGHT: rd_sel = {k_r[3], k_r[1], ~mask_bit};
      default:    rd_sel = {2'b00, ~mask_bit};
    endcase
    pix_color = (mode_r == MODE_FILL) ? {code_hi_r[6:0], code_lo_r} : cw_r[rd_sel][14:0];
  end

  // status
  always_comb begin
    sts           = '0;
    sts.dec_end   = run && (phase_r == v1d_pkg::PH_CODE_HI) && hi_end;
    sts.dec_skip  = run && (phase_r == v1d_pkg::PH_CODE_HI) && !hi_end && hi_skip
                    && (skip_cnt != 10'd0);
    sts.dec_emit  = run && (((phase_r == v1d_pkg::PH_CODE_HI) && !hi_end && !hi_skip
                    && hi_fill) || ((phase_r >= v1d_pkg::PH_COLORS)
                    && (emit_two || emit_eight)));
    sts.pix_last  = (k_r == 4'd15);
    sts.skip_last = rem_r <= {1'b0, steps};
    sts.out_free  = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    phase_nxt     = phase_r;
    code_lo_nxt   = code_lo_r;
    code_hi_nxt   = code_hi_r;
    col_nxt       = col_r;
    top_row_nxt   = top_row_r;
    bl_nxt        = bl_r;
    fin_nxt       = fin_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    cw_nxt        = cw_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    color_nxt     = color_r;
    last_nxt      = last_r;
    end_nxt       = end_r;

    if (cfg_we) begin
      case (cfg_idx)
        v1d_pkg::CFG_WIDTH:  width_nxt  = cfg_data;
        v1d_pkg::CFG_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end

    if (cmd.accept) begin
      k_nxt = 4'd0;
      if (in_frame_start) begin
        phase_nxt   = v1d_pkg::PH_CODE_LO;
        code_lo_nxt = 8'd0;
        code_hi_nxt = 8'd0;
        col_nxt     = 9'd0;
        top_row_nxt = top_start;
        bl_nxt      = bl_start;
        fin_nxt     = 1'b0;
      end
      if (in_frame_start || !fin_r) begin
        if (in_frame_start || (phase_r == v1d_pkg::PH_CODE_LO)) begin
          code_lo_nxt = in_byte;
          phase_nxt   = v1d_pkg::PH_CODE_HI;
        end else if (phase_r == v1d_pkg::PH_CODE_HI) begin
          code_hi_nxt = in_byte;
          bl_nxt      = bl_dec;
          phase_nxt   = v1d_pkg::PH_CODE_LO;
          if (hi_end) begin
            fin_nxt = 1'b1;
          end else if (hi_skip) begin
            bl_nxt  = bl_skip;
            rem_nxt = skip_cnt;
          end else if (hi_fill) begin
            mode_nxt = MODE_FILL;
          end else begin
            phase_nxt = v1d_pkg::PH_COLORS;
          end
        end else begin
          if (cw_pos[0]) begin
            cw_nxt[cw_sel] = {in_byte, cw_r[cw_sel][7:0]};
          end else begin
            cw_nxt[cw_sel] = {cw_r[cw_sel][15:8], in_byte};
          end
          phase_nxt = phase_inc;
          if (emit_two) begin
            mode_nxt  = MODE_TWO;
            phase_nxt = v1d_pkg::PH_CODE_LO;
          end else if (emit_eight) begin
            mode_nxt  = MODE_EIGHT;
            phase_nxt = v1d_pkg::PH_CODE_LO;
          end
        end
      end
    end

    if (cmd.skip_step) begin
      if (rem_r >= {1'b0, steps}) begin
        col_nxt     = 9'd0;
        top_row_nxt = tr_wrap;
        rem_nxt     = rem_r - {1'b0, steps};
      end else begin
        col_nxt = col_r + rem_r[8:0];
        rem_nxt = 10'd0;
      end
    end

    // output register
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_pix) begin
      out_valid_nxt = 1'b1;
      px_nxt        = {col_r[7:0], k_r[1:0]};
      py_nxt        = top_row_r[9:0] - {8'd0, k_r[3:2]};
      color_nxt     = pix_color;
      last_nxt      = (k_r == 4'd15);
      end_nxt       = 1'b0;
      k_nxt         = k_r + 4'd1;
      if (k_r == 4'd15) begin
        if (adv_wrap) begin
          col_nxt     = 9'd0;
          top_row_nxt = tr_wrap;
        end else begin
          col_nxt = col_inc;
        end
      end
    end
    if (cmd.load_end) begin
      out_valid_nxt = 1'b1;
      px_nxt        = 10'd0;
      py_nxt        = 10'd0;
      color_nxt     = 15'd0;
      last_nxt      = 1'b0;
      end_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= v1d_pkg::W_RST;
      height_r    <= v1d_pkg::H_RST;
      phase_r     <= v1d_pkg::PH_CODE_LO;
      code_lo_r   <= 8'd0;
      code_hi_r   <= 8'd0;
      col_r       <= 9'd0;
      top_row_r   <= v1d_pkg::TOP_RST;
      bl_r        <= v1d_pkg::BL_RST;
      fin_r       <= 1'b0;
      k_r         <= 4'd0;
      rem_r       <= 10'd0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      phase_r     <= phase_nxt;
      code_lo_r   <= code_lo_nxt;
      code_hi_r   <= code_hi_nxt;
      col_r       <= col_nxt;
      top_row_r   <= top_row_nxt;
      bl_r        <= bl_nxt;
      fin_r       <= fin_nxt;
      k_r         <= k_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cw_r    <= cw_nxt;
    mode_r  <= mode_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    color_r <= color_nxt;
    last_r  <= last_nxt;
    end_r   <= end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pix_x      = px_r;
  assign out_pix_y      = py_r;
  assign out_color      = color_r;
  assign out_block_last = last_r;
  assign out_frame_end  = end_r;

endmodule
`default_nettype wire

/* rtl/video1_16bit_block_decoder.sv */
// Code and color bytes are taken while idle; a block's last byte moves the controller to
//   its emit state, which loads one pixel per cycle into the output register while it is free.
// A fill block takes 2 bytes; a skip walks one block row per cycle; the end result waits
//   for a free output register.
// Reset (rst_n low, synchronous): 40x30 blocks, position at the top block row,
//   no pending result; the color word store is undefined until written.
`default_nettype none
module video1_16bit_block_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [v1d_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [v1d_pkg::CFG_DATA_W-1:0]    cfg_data,
  // encoded byte stream
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_byte,
  input  wire logic                              in_frame_start,
  // pixel writes
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [9:0]                             out_pix_x,
  output logic [9:0]                             out_pix_y,
  output logic [14:0]                            out_color,
  output logic                                   out_block_last,
  output logic                                   out_frame_end
);

  // Controller takes a byte per cycle in idle; a decoded block, a skip or the
  // end of the frame holds intake until its work is done.
  v1d_pkg::cmd_t    cmd;
  v1d_pkg::status_t sts;

  v1d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath holds the codes, color words, block position and the output
  // register, so a finished pixel can wait while the next byte transfers.
  v1d_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_byte        (in_byte),
    .in_frame_start (in_frame_start),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_pix_x      (out_pix_x),
    .out_pix_y      (out_pix_y),
    .out_color      (out_color),
    .out_block_last (out_block_last),
    .out_frame_end  (out_frame_end)
  );

endmodule
`default_nettype wire

/* rtl/v1d_checker.sv */
// Port-level checks for the decoder, bound to the top level.
`default_nettype none
module v1d_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              cfg_we,
  input wire logic [v1d_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input wire logic [v1d_pkg::CFG_DATA_W-1:0]    cfg_data,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic [7:0]                        in_byte,
  input wire logic                              in_frame_start,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [9:0]                        out_pix_x,
  input wire logic [9:0]                        out_pix_y,
  input wire logic [14:0]                       out_color,
  input wire logic                              out_block_last,
  input wire logic                              out_frame_end
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pix_x) && $stable(out_pix_y)
      && $stable(out_color) && $stable(out_block_last) && $stable(out_frame_end))
    else $error("result changed while stalled");

  // end result carries no pixel
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_pix_x == 10'd0 && out_pix_y == 10'd0
      && out_color == 15'd0 && !out_block_last)
    else $error("end result has pixel fields set");

  // last pixel of a block sits at its lower-right corner
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_last |-> out_pix_x[1:0] == 2'd3 && out_pix_y[1:0] == 2'd0
      && !out_frame_end)
    else $error("block last pixel misplaced");

  // no byte intake while a block is still being written out
  a_no_intake_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_block_last && !out_frame_end |-> !in_ready)
    else $error("byte taken during block output");

endmodule

bind video1_16bit_block_decoder v1d_checker u_v1d_checker (.*);
`default_nettype wire

/* tb/sv/tb_video1_16bit_block_decoder.sv */
// Self-checking bench for the Video 1 16-bit block decoder: byte stream in, pixel writes out.
`default_nettype none
module tb_video1_16bit_block_decoder;

  // codes the stimulus builds by name
  localparam logic [7:0] END_CODE   = 8'h00;  // both code bytes zero with the grid used up = end of frame
  localparam logic [7:0] LOW_7BITS  = 8'h7F;  // largest code_hi that still means colors
  localparam logic [15:0] QUAD_FLAG = 16'h8000;  // bit 15 of first color -> 8-color mode
  localparam int DRAIN_GUARD = 1100;  // longest skip walk: one block row per cycle, 1023 rows
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {
    PAINT_FILL,
    PAINT_TWO,
    PAINT_EIGHT
  } paint_t;

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [14:0] color;
    logic        last;
    logic        fend;
  } pixel_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fs;
  } enc_byte_t;

  // DUT signals; the inputs are known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [v1d_pkg::CFG_IDX_W-1:0] cfg_idx = v1d_pkg::CFG_WIDTH;
  logic [v1d_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = '0;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [9:0] out_pix_x;
  logic [9:0] out_pix_y;
  logic [14:0] out_color;
  logic out_block_last;
  logic out_frame_end;

  video1_16bit_block_decoder u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pix_x      (out_pix_x),
    .out_pix_y      (out_pix_y),
    .out_color      (out_color),
    .out_block_last (out_block_last),
    .out_frame_end  (out_frame_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder model state. Register copies follow every cfg write; the frame
  // state below mirrors the block and moves only on accepted byte transfers.
  // ---------------------------------------------------------------------------
  logic [8:0]  width_reg = v1d_pkg::W_RST;
  logic [8:0]  height_reg = v1d_pkg::H_RST;
  logic [4:0]  byte_phase;
  logic [7:0]  code_lo;
  logic [7:0]  code_hi;
  logic [15:0] color_word [8];
  int unsigned block_col;
  int          top_row;       // signed, parks at -1 once past the frame
  logic [16:0] blocks_left;
  bit          finished;

  pixel_t    pending_pixels[$];  // pixel writes still owed by the block
  enc_byte_t byte_stream[$];     // encoded bytes waiting for the driver

  int err_cnt = 0;
  int sent_cnt = 0;
  int pix_cnt = 0;
  int end_cnt = 0;
  int items_made = 0;
  int sizes_run = 0;
  bit fs_next = 1'b0;
  bit calm = 1'b0;             // no idling on either side
  int hold_seq = 0;            // bump to ask the receiver for a long hold-off

  function automatic int unsigned clamp_blocks(input logic [8:0] v);
    if (v == 9'd0) return 1;
    if (v > 9'(v1d_pkg::MAX_SIDE_BLOCKS)) return v1d_pkg::MAX_SIDE_BLOCKS;
    return 32'(v);
  endfunction

  task automatic restart_frame();
    byte_phase = v1d_pkg::PH_CODE_LO;
    code_lo = '0;
    code_hi = '0;
    block_col = 0;
    top_row = int'(4 * clamp_blocks(height_reg)) - 1;
    blocks_left = 17'(clamp_blocks(width_reg) * clamp_blocks(height_reg) + 1);
    finished = 1'b0;
  endtask

  // Width is read fresh here, so a narrower width wraps at the next advance.
  task automatic next_block();
    block_col++;
    if (block_col >= clamp_blocks(width_reg)) begin
      block_col = 0;
      if (top_row >= 0) top_row -= 4;
      if (top_row < 0) top_row = -1;
    end
  endtask

  // 16 writes, emit rows top down; 8-color mode picks a color pair per quadrant
  task automatic paint_block(input paint_t how, input logic [15:0] fill);
    logic [15:0] mask;
    logic [15:0] c;
    int q;
    int r;
    int i;
    pixel_t p;
    mask = {code_hi, code_lo};
    for (r = 0; r < 4; r++) begin
      for (i = 0; i < 4; i++) begin
        if (how == PAINT_FILL) begin
          c = fill;
        end else begin
          q = (how == PAINT_EIGHT) ? ((r >= 2) ? 2 : 0) + ((i >= 2) ? 1 : 0) : 0;
          c = mask[4 * r + i] ? color_word[2 * q] : color_word[2 * q + 1];
        end
        p.x = 10'(block_col * 4 + i);
        p.y = 10'(top_row - r);
        p.color = c[14:0];
        p.last = (r == 3 && i == 3);
        p.fend = 1'b0;
        pending_pixels.push_back(p);
      end
    end
    next_block();
    byte_phase = v1d_pkg::PH_CODE_LO;
  endtask

  // Works out the pixel writes one accepted byte causes.
  task automatic decode_byte(input logic [7:0] b, input logic fs);
    int unsigned slot;
    int unsigned w;
    int unsigned skip;
    pixel_t p;
    if (fs) restart_frame();
    if (finished) return;
    if (byte_phase == v1d_pkg::PH_CODE_LO) begin
      code_lo = b;
      byte_phase = v1d_pkg::PH_CODE_HI;
    end else if (byte_phase == v1d_pkg::PH_CODE_HI) begin
      code_hi = b;
      blocks_left = blocks_left - 17'd1;
      if ((code_lo == END_CODE && code_hi == END_CODE && blocks_left == '0) || top_row < 0) begin
        finished = 1'b1;
        byte_phase = v1d_pkg::PH_CODE_LO;
        p = '0;
        p.fend = 1'b1;
        pending_pixels.push_back(p);
      end else if (code_hi inside {[v1d_pkg::CODE_SKIP_LO : v1d_pkg::CODE_SKIP_HI]}) begin
        skip = ((int'(code_hi) - int'(v1d_pkg::CODE_SKIP_LO)) << 8) + int'(code_lo);
        // a zero skip moves nothing yet still gives the block count back
        blocks_left = blocks_left - 17'(skip) + 17'd1;
        repeat (skip) next_block();
        byte_phase = v1d_pkg::PH_CODE_LO;
      end else if (code_hi >= v1d_pkg::CODE_FILL) begin
        paint_block(PAINT_FILL, {code_hi, code_lo});
      end else begin
        byte_phase = v1d_pkg::PH_COLORS;
      end
    end else begin
      // color bytes arrive LE16, words 0..7
      slot = 32'(byte_phase - v1d_pkg::PH_COLORS);
      w = (slot >> 1) & 7;
      if (slot[0]) color_word[w][15:8] = b;
      else color_word[w][7:0] = b;
      byte_phase = byte_phase + 5'd1;
      if (byte_phase == v1d_pkg::PH_TWO_END && !color_word[0][15])
        paint_block(PAINT_TWO, '0);
      else if (byte_phase >= v1d_pkg::PH_EIGHT_END)
        paint_block(PAINT_EIGHT, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders: well-formed code/color byte runs, plus loose bytes and cut blocks.
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input bit counted);
    enc_byte_t it;
    it.data = b;
    it.fs = fs_next;
    fs_next = 1'b0;
    byte_stream.push_back(it);
    if (counted) items_made++;
  endtask

  task automatic push_word(input logic [15:0] w);
    push_byte(w[7:0], 1'b1);
    push_byte(w[15:8], 1'b1);
  endtask

  task automatic put_fill();
    logic [7:0] hi;
    do hi = 8'($urandom_range(v1d_pkg::CODE_FILL, 8'hFF));
    while (hi inside {[v1d_pkg::CODE_SKIP_LO : v1d_pkg::CODE_SKIP_HI]});
    push_byte(8'($urandom), 1'b1);
    push_byte(hi, 1'b1);
  endtask

  task automatic put_skip(input logic [9:0] n);
    push_byte(n[7:0], 1'b1);
    push_byte(v1d_pkg::CODE_SKIP_LO + 8'(n[9:8]), 1'b1);
  endtask

  // two-color or 8-color block; a zero mask now and then, which is not an end
  task automatic put_pattern(input bit eight);
    logic [15:0] mask;
    mask = ($urandom_range(0, 9) == 0) ? 16'h0 : {1'b0, 15'($urandom)};
    push_byte(mask[7:0], 1'b1);
    push_byte(mask[15:8], 1'b1);
    push_word(eight ? (QUAD_FLAG | 16'($urandom)) : (~QUAD_FLAG & 16'($urandom)));
    repeat (eight ? 7 : 1) push_word(16'($urandom));
  endtask

  // One frame of random blocks. Finishes with an end code or an overrun once the
  // grid is used up; otherwise the next frame start cuts it short. Stops early
  // once the byte budget is reached.
  task automatic random_frame(input int ops, input int target);
    int unsigned area;
    int unsigned used;
    int unsigned n;
    int pick;
    int k;
    bit lost;
    area = clamp_blocks(width_reg) * clamp_blocks(height_reg);
    used = 0;
    lost = 1'b0;
    fs_next = 1'b1;
    k = 0;
    while (k < ops && items_made < target) begin
      if (!lost && used >= area) begin
        if (used == area && $urandom_range(0, 3) != 0) begin
          push_byte(END_CODE, 1'b1);
          push_byte(END_CODE, 1'b1);
        end else begin
          put_fill();
        end
        // trailing bytes after the end are dropped by the block
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0);
        return;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        put_fill();
        used++;
      end else if (pick < 55) begin
        put_pattern(1'b0);
        used++;
      end else if (pick < 72) begin
        put_pattern(1'b1);
        used++;
      end else if (pick < 86) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 3);
        put_skip(10'(n));
        used += n;
      end else if (pick < 93) begin
        // loose bytes knock the code alignment out
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b1);
        lost = 1'b1;
      end else begin
        // half a block, then a new frame drops it
        push_byte(8'($urandom), 1'b1);
        push_byte(8'($urandom_range(0, LOW_7BITS)), 1'b1);
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b1);
        return;
      end
      k++;
    end
  endtask

  task automatic wait_idle();
    while (byte_stream.size() != 0 || in_valid || pending_pixels.size() != 0)
      @(posedge clk);
  endtask

  // Only while idle; a skip may still be walking rows after the last result.
  task automatic set_frame_size(input logic [8:0] w, input logic [8:0] h);
    wait_idle();
    repeat (DRAIN_GUARD) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= v1d_pkg::CFG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    width_reg = w;
    cfg_idx <= v1d_pkg::CFG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    height_reg = h;
    cfg_we <= 1'b0;
    sizes_run++;
  endtask

  task automatic run_random(input int target);
    while (items_made < target) random_frame($urandom_range(3, 12), target);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    err_cnt++;
    $display("mismatch on pixel write %0d: %s got %0h want %0h", pix_cnt, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one byte transfer per in_valid && in_ready, random gap bursts.
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    enc_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte, in_frame_start);
        sent_cnt++;
      end
      // payload holds while a transfer is pending
      if (!in_valid || in_ready) begin
        if (send_gap > 0 && !calm) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_stream.size() != 0 && !calm && $urandom_range(0, 19) == 0) begin
          send_gap = $urandom_range(1, 10) - 1;
          in_valid <= 1'b0;
        end else if (byte_stream.size() != 0) begin
          nxt = byte_stream.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt.data;
          in_frame_start <= nxt.fs;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stall bursts, plus a long hold-off on request.
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0 && !calm) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: every pixel write transfer against the oldest owed write.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("unexpected transfer", 32'({out_pix_y, out_pix_x}), '0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pix_x !== want.x)
          flag_mismatch("pix_x", 32'(out_pix_x), 32'(want.x));
        if (out_pix_y !== want.y)
          flag_mismatch("pix_y", 32'(out_pix_y), 32'(want.y));
        if (out_color !== want.color)
          flag_mismatch("color", 32'(out_color), 32'(want.color));
        if (out_block_last !== want.last)
          flag_mismatch("block_last", 32'(out_block_last), 32'(want.last));
        if (out_frame_end !== want.fend)
          flag_mismatch("frame_end", 32'(out_frame_end), 32'(want.fend));
        if (want.fend) end_cnt++;
      end
      pix_cnt++;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed frames, then random frames over a range of frame sizes.
  // ---------------------------------------------------------------------------
  initial begin
    int guard;
    foreach (color_word[j]) color_word[j] = '0;
    restart_frame();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // 2x1 grid: brightest fill, 8-color block, end code, junk, frame cut, long skip
    set_frame_size(9'd2, 9'd1);
    fs_next = 1'b1;
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h96, 1'b1);
    push_byte(8'h69, 1'b1);
    push_word(16'h8000);
    push_word(16'h7FFF);
    push_word(16'hFFFF);
    push_word(16'h0001);
    push_word(16'h5555);
    push_word(16'hAAAA);
    push_word(16'h0F0F);
    push_word(16'hF0F0);
    push_byte(END_CODE, 1'b1);
    push_byte(END_CODE, 1'b1);
    push_byte(8'hA5, 1'b0);
    fs_next = 1'b1;
    push_byte(8'h12, 1'b1);
    fs_next = 1'b1;
    put_skip(10'd1023);
    push_byte(8'h00, 1'b1);
    push_byte(v1d_pkg::CODE_FILL, 1'b1);

    set_frame_size(9'd3, 9'd2);
    run_random(70);
    set_frame_size(9'd0, 9'd0);
    run_random(100);
    set_frame_size(9'd1, 9'd3);
    run_random(130);
    set_frame_size(9'd511, 9'd1);
    run_random(165);

    // back-pressure: receiver holds off while fills keep coming
    set_frame_size(9'd4, 9'd4);
    fs_next = 1'b1;
    hold_seq++;
    repeat (14) put_fill();
    wait_idle();
    run_random(215);

    set_frame_size(9'd2, 9'd511);
    run_random(245);
    set_frame_size(9'd256, 9'd256);
    run_random(270);

    // last stretch runs flat out
    calm = 1'b1;
    set_frame_size(9'd5, 9'd3);
    run_random(330);

    guard = 0;
    while ((byte_stream.size() != 0 || in_valid || pending_pixels.size() != 0)
           && guard < 300000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_pixels.size() != 0)
      flag_mismatch("writes never seen", 32'(pending_pixels.size()), '0);
    repeat (64) @(posedge clk);

    $display("covered %0d byte transfers over %0d frame sizes", sent_cnt, sizes_run);
    $display("checked %0d pixel writes, %0d of them frame ends, %0d mismatches",
             pix_cnt, end_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
